FILE: src/ers_pkg.sv
// Shared types, constants and the curve table for the eased ramp sequencer.
`default_nettype none

package ers_pkg;

    // Segments and field layout of one segment word
    localparam int NUM_SEGMENTS      = 4;
    localparam int SEG_IDX_W         = $clog2(NUM_SEGMENTS);
    localparam int SEG_W             = 51;
    localparam int VALUE_WIDTH       = 16;
    localparam int DUR_W             = 16;
    localparam int MS_W              = 8;
    localparam int LOOP_W            = 8;
    localparam int LIMIT_W           = 9;
    localparam int COUNT_W           = 3;
    localparam int CURVE_CODE_W      = 3;

    // Curve table
    localparam int CURVE_KINDS       = 6;
    localparam int CURVE_TABLE_DEPTH = 256;
    localparam int PHASE_W           = $clog2(CURVE_TABLE_DEPTH);
    localparam int CURVE_W           = 16;
    localparam int ROM_AW            = CURVE_CODE_W + PHASE_W;
    localparam int DIV_STEPS         = PHASE_W;
    localparam int STEP_W            = $clog2(DIV_STEPS);

    // Shared adder width and product width
    localparam int ALU_W             = 18;
    localparam int DIFF_W            = VALUE_WIDTH + 1;
    localparam int PROD_W            = 2 * DIFF_W;

    // Configuration port
    localparam int PADDR_W           = 6;
    localparam int PDATA_W           = 64;
    localparam int REG_IDX_W         = 3;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_SEG_WORD_0 = 3'd0;
    localparam reg_idx_t REG_SEG_WORD_1 = 3'd1;
    localparam reg_idx_t REG_SEG_WORD_2 = 3'd2;
    localparam reg_idx_t REG_SEG_WORD_3 = 3'd3;
    localparam reg_idx_t REG_SEG_COUNT  = 3'd4;
    localparam reg_idx_t REG_LOOP_LIMIT = 3'd5;

    // Item kinds on the input channel
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Curve codes
    typedef logic [CURVE_CODE_W-1:0] curve_code_t;
    localparam curve_code_t CURVE_LINEAR      = 3'd0;
    localparam curve_code_t CURVE_QUADRATIC   = 3'd1;
    localparam curve_code_t CURVE_SINUSOIDAL  = 3'd2;
    localparam curve_code_t CURVE_HYPERBOLIC  = 3'd3;
    localparam curve_code_t CURVE_LOGARITHMIC = 3'd4;
    localparam curve_code_t CURVE_EXPONENTIAL = 3'd5;

    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [NUM_SEGMENTS-1:0][SEG_W-1:0] seg_word;
        logic [COUNT_W-1:0]                 seg_count;
        logic signed [LIMIT_W-1:0]          loop_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
        logic                    sub;
        logic                    cin;
    } alu_req_t;

    // Lowest bits first: value, finished, segment_now, loops_done
    typedef struct packed {
        logic [LOOP_W-1:0]             loops_done;
        logic [SEG_IDX_W-1:0]          segment_now;
        logic                          finished;
        logic signed [VALUE_WIDTH-1:0] value;
    } result_t;

    localparam int OUT_PAD_W = OUT_TDATA_W - $bits(result_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_CMP,
        S_DIV,
        S_LOOK,
        S_MUL,
        S_SUM,
        S_OUT
    } seq_state_t;

    // ------------------------------------------------------------------
    // Curve table, built at elaboration from Q30 integer series.
    // ------------------------------------------------------------------
    typedef logic [CURVE_KINDS*CURVE_TABLE_DEPTH-1:0][CURVE_W-1:0] curve_rom_t;

    localparam logic [63:0] Q30_ONE = 64'h0000_0000_4000_0000;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    localparam logic [63:0] Q15_ONE = 64'd32768;

    // Shift-subtract quotient, used only while the table is elaborated
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] q15_ratio(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        if (den == 64'd0)
            return Q15_ONE;
        q = udiv64((num << 15) + (den >> 1), den);
        return (q > Q15_ONE) ? Q15_ONE : q;
    endfunction

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++)
        begin
            term = udiv64((((term * x) >> 30) * x) >> 30, 64'((2 * k) * (2 * k + 1)));
            if (k[0])
                sum = (sum > term) ? sum - term : 64'd0;
            else
                sum = sum + term;
        end
        return (sum > Q30_ONE) ? Q30_ONE : sum;
    endfunction

    function automatic logic [63:0] exp_neg8_q30(input logic [63:0] z);
        logic [63:0] term;
        logic [63:0] sum;
        term = Q30_ONE;
        sum  = Q30_ONE;
        for (int k = 1; k <= 10; k++)
        begin
            term = udiv64((term * z) >> 30, 64'(k));
            if (k[0])
                sum = (sum > term) ? sum - term : 64'd0;
            else
                sum = sum + term;
        end
        for (int k = 0; k < 3; k++)
            sum = (sum * sum) >> 30;
        return sum;
    endfunction

    function automatic logic [63:0] ln_q30(input logic [63:0] v);
        logic [63:0] k;
        logic [63:0] m;
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] term;
        logic [63:0] sum;
        k = '0;
        for (int j = 0; j < 40; j++)
        begin
            if ((v >> k) >= (Q30_ONE << 1))
                k = k + 64'd1;
        end
        m  = v >> k;
        s  = udiv64((m - Q30_ONE) << 30, m + Q30_ONE);
        s2 = (s * s) >> 30;
        term = s;
        sum  = s;
        for (int n = 1; n <= 12; n++)
        begin
            term = (term * s2) >> 30;
            sum  = sum + udiv64(term, 64'(2 * n + 1));
        end
        return (sum << 1) + k * LN2_Q30;
    endfunction

    function automatic curve_rom_t build_curve_rom();
        curve_rom_t  rom;
        logic [63:0] d;
        logic [63:0] iv;
        logic [63:0] ln100;
        logic [63:0] e4;
        logic [63:0] s;
        logic [63:0] e;
        rom   = '0;
        d     = 64'(CURVE_TABLE_DEPTH);
        ln100 = ln_q30(64'd100 * Q30_ONE);
        e4    = exp_neg8_q30(Q30_ONE >> 1);
        for (int i = 0; i < CURVE_TABLE_DEPTH; i++)
        begin
            iv = 64'(i);
            rom[int'(CURVE_LINEAR) * CURVE_TABLE_DEPTH + i] = CURVE_W'(q15_ratio(iv, d));
            rom[int'(CURVE_QUADRATIC) * CURVE_TABLE_DEPTH + i] =
                CURVE_W'(q15_ratio(iv * ((d << 1) - iv), d * d));
            s = sin_q30(udiv64(PI_Q30 * iv, d << 1));
            s = (((s * s) >> 30) + 64'd16384) >> 15;
            rom[int'(CURVE_SINUSOIDAL) * CURVE_TABLE_DEPTH + i] =
                CURVE_W'((s > Q15_ONE) ? Q15_ONE : s);
            rom[int'(CURVE_HYPERBOLIC) * CURVE_TABLE_DEPTH + i] =
                CURVE_W'(q15_ratio(iv, (d << 2) - 64'd3 * iv));
            rom[int'(CURVE_LOGARITHMIC) * CURVE_TABLE_DEPTH + i] =
                CURVE_W'(q15_ratio(ln_q30(Q30_ONE + udiv64(64'd99 * iv * Q30_ONE, d)), ln100));
            e = exp_neg8_q30(udiv64(iv * Q30_ONE, d << 1));
            rom[int'(CURVE_EXPONENTIAL) * CURVE_TABLE_DEPTH + i] =
                CURVE_W'(q15_ratio(Q30_ONE - ((e > Q30_ONE) ? Q30_ONE : e), Q30_ONE - e4));
        end
        return rom;
    endfunction

    localparam curve_rom_t CURVE_ROM = build_curve_rom();

endpackage

`default_nettype wire

FILE: src/eased_ramp_sequencer.sv
// Top level of the eased ramp sequencer: stream channels, APB configuration port.
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  tuser: op; tdata: elapsed_ms
//  m_*       out        m_tvalid/m_tready  tdata: value, finished, segment_now, loops_done
//  APB       in/out     psel/penable       segment words, segment count, loop limit
//
//  A restart item, or an advance while finished, goes straight to the output state;
//  an advance passes the add and compare states, and one inside a segment then runs
//  the bit-serial phase divider on the shared adder, the lookup, multiply and sum.
//  Reset clears the sequencer state and the registers; no clearing pass is needed.
//  The input is accepted only while the sequencer is idle; a finished result waits in
//  the output register, and the next item may be accepted meanwhile.
`default_nettype none

module eased_ramp_sequencer
    import ers_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Input item stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [MS_W-1:0]        s_tdata,   // [7:0] elapsed_ms
    input  logic                   s_tuser,   // [0] op: restart or advance

    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [15:0] value, [16] finished,
                                              // [18:17] segment_now, [26:19] loops_done

    // Configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    cfg_t    cfg;
    result_t result;

    // Register file: each register sits at a 64-bit aligned address.
    ers_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The sequencer owns the segment state, the shared adder, the curve table
    // lookup, the multiplier and the output register.
    ers_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_ms     (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    // Results are packed with the value in the lowest bits, padded with zeros.
    assign m_tdata = {{OUT_PAD_W{1'b0}}, result};

endmodule

`default_nettype wire

FILE: src/ers_alu.sv
// Shared add/subtract unit used by every add, subtract and compare step of the sequencer.
`default_nettype none

module ers_alu
    import ers_pkg::*;
(
    input  alu_req_t                req,
    output logic signed [ALU_W-1:0] res
);

    logic [ALU_W-1:0] b_eff;
    logic [ALU_W-1:0] carry_in;

    always_comb
    begin
        b_eff    = req.sub ? ~req.b : req.b;
        carry_in = {{(ALU_W-1){1'b0}}, (req.sub | req.cin)};
        res      = req.a + b_eff + carry_in;
    end

endmodule

`default_nettype wire

FILE: src/ers_curve_rom.sv
// Registered lookup into the constant curve table.
`default_nettype none

module ers_curve_rom
    import ers_pkg::*;
(
    input  logic               clk,
    input  curve_code_t        kind,
    input  logic [PHASE_W-1:0] phase,
    output logic [CURVE_W-1:0] curve_val
);

    logic [CURVE_W-1:0] curve_reg;
    logic [CURVE_W-1:0] curve_next;
    logic [ROM_AW-1:0]  addr;

    always_comb
    begin
        addr       = {kind, phase};
        curve_next = CURVE_ROM[addr];
    end

    always_ff @(posedge clk)
    begin
        curve_reg <= curve_next;
    end

    assign curve_val = curve_reg;

endmodule

`default_nettype wire

FILE: src/ers_cfg_regs.sv
// APB register file holding the segment words, segment count and loop limit.
`default_nettype none

module ers_cfg_regs
    import ers_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx) inside
                REG_SEG_WORD_0, REG_SEG_WORD_1, REG_SEG_WORD_2, REG_SEG_WORD_3:
                    cfg_next.seg_word[reg_idx[SEG_IDX_W-1:0]] = pwdata[SEG_W-1:0];
                REG_SEG_COUNT:
                    cfg_next.seg_count = pwdata[COUNT_W-1:0];
                REG_LOOP_LIMIT:
                    cfg_next.loop_limit = pwdata[LIMIT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx) inside
            REG_SEG_WORD_0, REG_SEG_WORD_1, REG_SEG_WORD_2, REG_SEG_WORD_3:
                prdata = {{(PDATA_W-SEG_W){1'b0}}, cfg_reg.seg_word[reg_idx[SEG_IDX_W-1:0]]};
            REG_SEG_COUNT:
                prdata = {{(PDATA_W-COUNT_W){1'b0}}, cfg_reg.seg_count};
            REG_LOOP_LIMIT:
                prdata = {{(PDATA_W-LIMIT_W){1'b0}}, cfg_reg.loop_limit};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seg_word   <= '0;
            cfg_reg.seg_count  <= '0;
            cfg_reg.loop_limit <= 9'sd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: src/ers_seq.sv
// Sequencer: segment, loop and time state, phase divider, interpolation and output register.
`default_nettype none

module ers_seq
    import ers_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_op,
    input  logic [MS_W-1:0] in_ms,
    output logic            out_valid,
    input  logic            out_ready,
    output result_t         out_data
);

    seq_state_t state_reg;
    seq_state_t state_next;

    logic [SEG_IDX_W-1:0]          seg_index_reg;
    logic [SEG_IDX_W-1:0]          seg_index_next;
    logic [LOOP_W-1:0]             loop_counter_reg;
    logic [LOOP_W-1:0]             loop_counter_next;
    logic [DUR_W-1:0]              elapsed_reg;
    logic [DUR_W-1:0]              elapsed_next;
    logic signed [VALUE_WIDTH-1:0] held_reg;
    logic signed [VALUE_WIDTH-1:0] held_next;
    logic [MS_W-1:0]               ms_reg;
    logic [MS_W-1:0]               ms_next;
    logic [DUR_W-1:0]              rem_reg;
    logic [DUR_W-1:0]              rem_next;
    logic [PHASE_W-1:0]            quot_reg;
    logic [PHASE_W-1:0]            quot_next;
    logic [STEP_W-1:0]             step_reg;
    logic [STEP_W-1:0]             step_next;
    logic signed [DIFF_W-1:0]      diff_reg;
    logic signed [DIFF_W-1:0]      diff_next;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      prod_next;
    logic                          fin_reg;
    logic                          fin_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    result_t                       out_data_reg;
    result_t                       out_data_next;

    logic [SEG_W-1:0]              word;
    logic signed [VALUE_WIDTH-1:0] start_val;
    logic signed [VALUE_WIDTH-1:0] end_val;
    logic [DUR_W-1:0]              dur;
    curve_code_t                   curve_code;
    curve_code_t                   curve_kind;
    logic [COUNT_W-1:0]            act_count;
    logic                          all_done;
    logic                          restart_done;
    logic                          seg_wrap;
    logic [LOOP_W-1:0]             loop_inc;
    logic                          alu_ge;
    logic [CURVE_W-1:0]            curve_val;
    logic signed [PROD_W-1:0]      prod_full;

    alu_req_t                alu_req;
    logic signed [ALU_W-1:0] alu_res;

    function automatic logic limit_hit(input logic signed [LIMIT_W-1:0] lim,
                                       input logic [LOOP_W-1:0] cnt);
        return !lim[LIMIT_W-1] && (cnt >= lim[LOOP_W-1:0]);
    endfunction

    ers_alu u_alu
    (
        .req (alu_req),
        .res (alu_res)
    );

    ers_curve_rom u_curve_rom
    (
        .clk       (clk),
        .kind      (curve_kind),
        .phase     (quot_reg),
        .curve_val (curve_val)
    );

    // Fields of the running segment
    always_comb
    begin
        word       = cfg.seg_word[seg_index_reg];
        start_val  = word[15:0];
        end_val    = word[31:16];
        dur        = word[47:32];
        curve_code = word[50:48];
        curve_kind = (curve_code >= CURVE_CODE_W'(CURVE_KINDS)) ? CURVE_LINEAR : curve_code;
        act_count  = (cfg.seg_count > COUNT_W'(NUM_SEGMENTS)) ?
                     COUNT_W'(NUM_SEGMENTS) : cfg.seg_count;
        all_done   = (act_count == '0) ||
                     ({1'b0, seg_index_reg} >= act_count) ||
                     limit_hit(cfg.loop_limit, loop_counter_reg);
        restart_done = (act_count == '0) || limit_hit(cfg.loop_limit, '0);
        seg_wrap   = (COUNT_W'(seg_index_reg) + COUNT_W'(1)) >= act_count;
        loop_inc   = (loop_counter_reg == {LOOP_W{1'b1}}) ?
                     loop_counter_reg : loop_counter_reg + LOOP_W'(1);
        alu_ge     = !alu_res[ALU_W-1];
        prod_full  = diff_reg * $signed({1'b0, curve_val});
    end

    always_comb
    begin
        state_next        = state_reg;
        seg_index_next    = seg_index_reg;
        loop_counter_next = loop_counter_reg;
        elapsed_next      = elapsed_reg;
        held_next         = held_reg;
        ms_next           = ms_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;
        step_next         = step_reg;
        diff_next         = diff_reg;
        prod_next         = prod_reg;
        fin_next          = fin_reg;
        out_data_next     = out_data_reg;
        out_valid_next    = out_valid_reg & ~out_ready;
        alu_req           = '0;
        in_ready          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ms_next = in_ms;
                    if (in_op == OP_RESTART)
                    begin
                        seg_index_next    = '0;
                        loop_counter_next = '0;
                        elapsed_next      = '0;
                        fin_next          = restart_done;
                        if (!restart_done)
                            held_next = cfg.seg_word[0][VALUE_WIDTH-1:0];
                        state_next = S_OUT;
                    end
                    else if (all_done)
                    begin
                        fin_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_ADD;
                    end
                end
            end
            S_ADD:
            begin
                alu_req.a = {2'b00, elapsed_reg};
                alu_req.b = {{(ALU_W-MS_W){1'b0}}, ms_reg};
                elapsed_next = alu_res[DUR_W] ? {DUR_W{1'b1}} : alu_res[DUR_W-1:0];
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                alu_req.a   = {2'b00, elapsed_reg};
                alu_req.b   = {2'b00, dur};
                alu_req.sub = 1'b1;
                if (alu_ge)
                begin
                    held_next    = end_val;
                    elapsed_next = '0;
                    if (seg_wrap)
                    begin
                        seg_index_next    = '0;
                        loop_counter_next = loop_inc;
                        fin_next          = limit_hit(cfg.loop_limit, loop_inc);
                    end
                    else
                    begin
                        seg_index_next = seg_index_reg + SEG_IDX_W'(1);
                        fin_next       = limit_hit(cfg.loop_limit, loop_counter_reg);
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    rem_next   = elapsed_reg;
                    quot_next  = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // One quotient bit of elapsed * depth / duration per cycle
                alu_req.a   = {1'b0, rem_reg, 1'b0};
                alu_req.b   = {2'b00, dur};
                alu_req.sub = 1'b1;
                rem_next    = alu_ge ? alu_res[DUR_W-1:0] : {rem_reg[DUR_W-2:0], 1'b0};
                quot_next   = {quot_reg[PHASE_W-2:0], alu_ge};
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                alu_req.a   = {{2{end_val[VALUE_WIDTH-1]}}, end_val};
                alu_req.b   = {{2{start_val[VALUE_WIDTH-1]}}, start_val};
                alu_req.sub = 1'b1;
                diff_next   = alu_res[DIFF_W-1:0];
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = prod_full;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // Round half up: floor(prod / 2^15) plus bit 14 of the product
                alu_req.a   = {{2{start_val[VALUE_WIDTH-1]}}, start_val};
                alu_req.b   = prod_reg[32:15];
                alu_req.cin = prod_reg[14];
                held_next   = alu_res[VALUE_WIDTH-1:0];
                fin_next    = 1'b0;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.value       = held_reg;
                    out_data_next.finished    = fin_reg;
                    out_data_next.segment_now = seg_index_reg;
                    out_data_next.loops_done  = loop_counter_reg;
                    out_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_index_reg    <= '0;
            loop_counter_reg <= '0;
            elapsed_reg      <= '0;
            held_reg         <= '0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            seg_index_reg    <= seg_index_next;
            loop_counter_reg <= loop_counter_next;
            elapsed_reg      <= elapsed_next;
            held_reg         <= held_next;
            step_reg         <= step_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ms_reg       <= ms_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        fin_reg      <= fin_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The divider remainder always stays below the duration
    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < dur))
        else $error("divider remainder reached the duration");

    // An accepted item always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start");

    // Pass count only rises while an advance is being worked
    a_loop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> (loop_counter_reg >= $past(loop_counter_reg)))
        else $error("pass count fell during an advance");

    // Finishing an item presents the result and frees the input
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!out_valid_reg || out_ready)) |=>
        (out_valid_reg && state_reg == S_IDLE))
        else $error("result not presented on completion");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the eased ramp sequencer: stream items, APB set-up, checked results.
`default_nettype none

module tb
    import ers_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The slowest correct run is roughly 1250 items, plus one long output stall; the
    // cycle limit below leaves several times that.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Cycles allowed for the sequencer to come to rest once the last result has been taken.
    localparam int SETTLE_WAIT  = 32;
    localparam int RANDOM_ITEMS = 80;

    typedef bit [63:0] u64_t;

    // ------------------------------------------------------------------
    // Block connections. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [MS_W-1:0]        s_tdata  = '0;
    logic                   s_tuser  = OP_RESTART;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]     pwdata   = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    eased_ramp_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [7:0] elapsed_ms
        .s_tuser  (s_tuser),     // [0] op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // [15:0] value, [16] finished, [18:17] segment_now,
                                 // [26:19] loops_done
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Own copy of the sequencer: configuration, state and curve table.
    // All of it starts in the post-reset condition.
    // ------------------------------------------------------------------
    logic [SEG_W-1:0] cfg_word [NUM_SEGMENTS] = '{default: '0};
    int               cfg_count = 0;
    int               cfg_limit = 1;

    int               st_seg     = 0;
    int               st_loops   = 0;
    int               st_elapsed = 0;
    logic [15:0]      st_held    = '0;

    bit [15:0]        ease_table [CURVE_KINDS][CURVE_TABLE_DEPTH];

    // Results the block still owes, oldest first.
    result_t          tween_due [$];

    int               fault_count     = 0;
    int               cycle_count     = 0;
    // While set, items go back to back and the receiver stalls only for a requested long hold.
    bit               steady_flow     = 1'b0;
    // A long output stall requested by a test; the receiver counts it down.
    int               hold_off_cycles = 0;

    // ------------------------------------------------------------------
    // Fixed-point series for the curve table in Q30, with ratios rounded to Q15.
    // ------------------------------------------------------------------
    function automatic u64_t ratio_q15(input u64_t num, input u64_t den);
        u64_t q;
        if (den == 0)
            return 64'd32768;
        q = (num * 64'd32768 + den / 2) / den;
        return (q > 64'd32768) ? 64'd32768 : q;
    endfunction

    // Taylor series of the sine over a quarter turn.
    function automatic u64_t sine_fix(input u64_t x);
        u64_t term;
        u64_t sum;
        u64_t div;
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++)
        begin
            div  = u64_t'(2 * k) * u64_t'(2 * k + 1);
            term = ((((term * x) >> 30) * x) >> 30) / div;
            if (k % 2 == 1)
                sum = (sum > term) ? sum - term : 64'd0;
            else
                sum = sum + term;
        end
        return (sum > Q30_ONE) ? Q30_ONE : sum;
    endfunction

    // e^(-z) by series, then squared three times over to give e^(-8z).
    function automatic u64_t decay8_fix(input u64_t z);
        u64_t term;
        u64_t sum;
        term = Q30_ONE;
        sum  = Q30_ONE;
        for (int k = 1; k <= 10; k++)
        begin
            term = ((term * z) >> 30) / u64_t'(k);
            if (k % 2 == 1)
                sum = (sum > term) ? sum - term : 64'd0;
            else
                sum = sum + term;
        end
        for (int k = 0; k < 3; k++)
            sum = (sum * sum) >> 30;
        return sum;
    endfunction

    // Natural log: halve into [1, 2), then the atanh series.
    function automatic u64_t log_fix(input u64_t v);
        int   k;
        u64_t m;
        u64_t s;
        u64_t s2;
        u64_t term;
        u64_t sum;
        k = 0;
        while (((v >> k) >= (Q30_ONE << 1)) && k < 40)
            k++;
        m    = v >> k;
        s    = ((m - Q30_ONE) << 30) / (m + Q30_ONE);
        s2   = (s * s) >> 30;
        term = s;
        sum  = s;
        for (int n = 1; n <= 12; n++)
        begin
            term = (term * s2) >> 30;
            sum  = sum + term / u64_t'(2 * n + 1);
        end
        return 2 * sum + u64_t'(k) * LN2_Q30;
    endfunction

    function automatic void build_ease_table();
        u64_t d;
        u64_t i;
        u64_t s;
        u64_t e;
        u64_t ln100;
        u64_t e4;
        d     = CURVE_TABLE_DEPTH;
        ln100 = log_fix(64'd100 * Q30_ONE);
        e4    = decay8_fix(Q30_ONE / 2);
        for (int n = 0; n < CURVE_TABLE_DEPTH; n++)
        begin
            i = n;
            ease_table[CURVE_LINEAR][n]    = 16'(ratio_q15(i, d));
            ease_table[CURVE_QUADRATIC][n] = 16'(ratio_q15(i * (2 * d - i), d * d));
            s = sine_fix((PI_Q30 * i) / (2 * d));
            s = (((s * s) >> 30) + 64'd16384) >> 15;
            ease_table[CURVE_SINUSOIDAL][n]  = 16'((s > 64'd32768) ? 64'd32768 : s);
            ease_table[CURVE_HYPERBOLIC][n]  = 16'(ratio_q15(i, 4 * d - 3 * i));
            ease_table[CURVE_LOGARITHMIC][n] =
                16'(ratio_q15(log_fix(Q30_ONE + (64'd99 * i * Q30_ONE) / d), ln100));
            e = decay8_fix((i * Q30_ONE) / (2 * d));
            ease_table[CURVE_EXPONENTIAL][n] =
                16'(ratio_q15(Q30_ONE - ((e > Q30_ONE) ? Q30_ONE : e), Q30_ONE - e4));
        end
    endfunction

    // ------------------------------------------------------------------
    // Prediction of one result from one accepted item.
    // ------------------------------------------------------------------
    function automatic result_t tween_snapshot(input bit fin);
        result_t r;
        r.value       = st_held;
        r.finished    = fin;
        r.segment_now = st_seg[SEG_IDX_W-1:0];
        r.loops_done  = st_loops[LOOP_W-1:0];
        return r;
    endfunction

    // Finished when there is nothing to run, the index lies beyond a lowered count,
    // or a non-negative loop limit has been met.
    function automatic bit tween_done(input int act);
        if (act == 0 || st_seg >= act)
            return 1'b1;
        return cfg_limit >= 0 && st_loops >= cfg_limit;
    endfunction

    function automatic result_t tween_next(input logic op, input logic [MS_W-1:0] ms);
        int               act;
        logic [SEG_W-1:0] w;
        longint           from_v;
        longint           to_v;
        longint           prod;
        longint           q;
        int               span;
        int               shape;
        int               idx;
        act = (cfg_count > NUM_SEGMENTS) ? NUM_SEGMENTS : cfg_count;
        if (op == OP_RESTART)
        begin
            st_seg     = 0;
            st_loops   = 0;
            st_elapsed = 0;
            if (tween_done(act))
                return tween_snapshot(1'b1);
            st_held = cfg_word[0][15:0];
            return tween_snapshot(1'b0);
        end
        if (tween_done(act))
            return tween_snapshot(1'b1);

        st_elapsed = st_elapsed + int'(ms);
        if (st_elapsed > 65535)
            st_elapsed = 65535;

        w      = cfg_word[st_seg];
        from_v = $signed(w[15:0]);
        to_v   = $signed(w[31:16]);
        span   = int'(w[47:32]);
        shape  = int'(w[50:48]);
        if (shape >= CURVE_KINDS)
            shape = CURVE_LINEAR;

        // End of the segment: its end value, overshoot dropped, on to the next one.
        if (st_elapsed >= span)
        begin
            st_held    = w[31:16];
            st_elapsed = 0;
            st_seg     = st_seg + 1;
            if (st_seg >= act)
            begin
                st_seg = 0;
                if (st_loops < 255)
                    st_loops = st_loops + 1;
            end
            return tween_snapshot(cfg_limit >= 0 && st_loops >= cfg_limit);
        end

        idx = (st_elapsed * CURVE_TABLE_DEPTH) / span;
        if (idx >= CURVE_TABLE_DEPTH)
            idx = CURVE_TABLE_DEPTH - 1;
        prod    = (to_v - from_v) * longint'(ease_table[shape][idx]);
        q       = (prod + 16384) >>> 15;
        st_held = 16'(from_v + q);
        return tween_snapshot(1'b0);
    endfunction

    function automatic void apply_setting(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        case (idx)
            REG_SEG_WORD_0, REG_SEG_WORD_1, REG_SEG_WORD_2, REG_SEG_WORD_3:
                cfg_word[int'(idx)] = val[SEG_W-1:0];
            REG_SEG_COUNT:
                cfg_count = int'(val[COUNT_W-1:0]);
            REG_LOOP_LIMIT:
                cfg_limit = int'($signed(val[LIMIT_W-1:0]));
            default: ;
        endcase
    endfunction

    function automatic logic [PDATA_W-1:0] seg_word(input logic [15:0] from_v,
                                                    input logic [15:0] to_v,
                                                    input logic [15:0] span,
                                                    input curve_code_t shape);
        return PDATA_W'({shape, span, to_v, from_v});
    endfunction

    // Random segment: levels sometimes at the extremes, durations mostly short,
    // now and then zero or anything up to the full 16 bits. Curve codes cover all eight.
    function automatic logic [PDATA_W-1:0] rand_seg_word();
        logic [15:0] from_v;
        logic [15:0] to_v;
        logic [15:0] span;
        int          r;
        from_v = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                                             : 16'($urandom);
        to_v   = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                                             : 16'($urandom);
        r      = $urandom_range(0, 15);
        span   = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom) : 16'($urandom_range(1, 1200));
        return seg_word(from_v, to_v, span, curve_code_t'($urandom_range(0, 7)));
    endfunction

    // No gap in steady flow; otherwise mostly none, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything is driven with nonblocking assignments right after a rising
    // edge, and ready lines are looked at just after the edge, so they show the value
    // the edge itself saw.
    // ------------------------------------------------------------------

    // Offers one item and returns at the edge that accepts it. tvalid is left high, so
    // that a following item with no gap goes out without a break.
    task automatic send_item(input logic op, input logic [MS_W-1:0] ms);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ms;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tween_due.push_back(tween_next(op, ms));
    endtask

    // Setup then access; the register is taken at the access edge. psel stays high so
    // that writes can follow one another; apb_release ends a group of them.
    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(8 * int'(idx));
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        apply_setting(idx, val);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_ramp(input logic [PDATA_W-1:0] w0, input logic [PDATA_W-1:0] w1,
                                input logic [PDATA_W-1:0] w2, input logic [PDATA_W-1:0] w3,
                                input logic [COUNT_W-1:0] count,
                                input logic [LIMIT_W-1:0] limit);
        write_reg(REG_SEG_WORD_0, w0);
        write_reg(REG_SEG_WORD_1, w1);
        write_reg(REG_SEG_WORD_2, w2);
        write_reg(REG_SEG_WORD_3, w3);
        write_reg(REG_SEG_COUNT, PDATA_W'(count));
        write_reg(REG_LOOP_LIMIT, PDATA_W'(limit));
        apb_release();
    endtask

    // Stop offering, wait for every owed result, then give the sequencer time to come to
    // rest so that the registers may be rewritten safely.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tween_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests, run in turn.
    // ------------------------------------------------------------------

    // Straight after reset there are no segments, so both kinds of item report finished
    // and the value stays at zero. A loop limit of zero finishes the run at restart.
    task automatic test_no_segments();
        send_item(OP_RESTART, 8'd0);
        send_item(OP_ADVANCE, 8'hFF);
        settle();
        write_reg(REG_SEG_WORD_0, seg_word(16'd5, 16'd9, 16'd10, CURVE_LINEAR));
        write_reg(REG_SEG_COUNT, PDATA_W'(1));
        write_reg(REG_LOOP_LIMIT, PDATA_W'(0));
        apb_release();
        send_item(OP_RESTART, 8'd0);
        settle();
    endtask

    // The first four curves, one per segment, each looked up part way through and then
    // run past its end; levels at both extremes. The last advance finds the run finished.
    task automatic test_curve_shapes();
        program_ramp(seg_word(16'h8000, 16'h7FFF, 16'd300, CURVE_LINEAR),
                     seg_word(16'h7FFF, 16'h8000, 16'd300, CURVE_QUADRATIC),
                     seg_word(16'h0000, 16'h7FFF, 16'd400, CURVE_SINUSOIDAL),
                     seg_word(16'd100, 16'(-100), 16'd256, CURVE_HYPERBOLIC),
                     3'd4, 9'd1);
        send_item(OP_RESTART, 8'd0);
        send_item(OP_ADVANCE, 8'd0);
        repeat (8) send_item(OP_ADVANCE, 8'hFF);
        send_item(OP_ADVANCE, 8'd17);
        settle();
    endtask

    // The remaining curve codes, a count above four, a zero-length segment, looping for
    // ever, and finally an index left beyond a count that has been lowered.
    task automatic test_finish_rules();
        program_ramp(seg_word(16'(-1000), 16'd30000, 16'd200, CURVE_LOGARITHMIC),
                     seg_word(16'h7FFF, 16'h8000, 16'd150, CURVE_EXPONENTIAL),
                     seg_word(16'd1234, 16'(-4321), 16'd0, curve_code_t'(6)),
                     seg_word(16'h8000, 16'd77, 16'd255, curve_code_t'(7)),
                     3'd7, 9'h1FF);
        send_item(OP_RESTART, 8'd0);
        send_item(OP_ADVANCE, 8'd100);
        send_item(OP_ADVANCE, 8'hFF);
        send_item(OP_ADVANCE, 8'd100);
        send_item(OP_ADVANCE, 8'hFF);
        // Zero duration: over at the first advance.
        send_item(OP_ADVANCE, 8'd7);
        send_item(OP_ADVANCE, 8'd128);
        send_item(OP_ADVANCE, 8'hFF);
        // Second pass, stopping at the start of the third segment.
        send_item(OP_ADVANCE, 8'd100);
        send_item(OP_ADVANCE, 8'hFF);
        send_item(OP_ADVANCE, 8'd100);
        send_item(OP_ADVANCE, 8'hFF);
        settle();
        // With only one segment left in use the running index is out of range.
        write_reg(REG_SEG_COUNT, PDATA_W'(1));
        apb_release();
        send_item(OP_ADVANCE, 8'd1);
        send_item(OP_RESTART, 8'hFF);
        settle();
    endtask

    // Random settings and random items. Phases start with a restart only half the time,
    // so that state from the previous setting carries over into the new one.
    task automatic test_random_ramps();
        int               r;
        logic [COUNT_W-1:0] count;
        logic [LIMIT_W-1:0] limit;
        logic [MS_W-1:0]    ms;
        for (int phase = 0; phase < 8; phase++)
        begin
            r     = $urandom_range(0, 9);
            count = (r == 0) ? 3'd0 : (r == 1) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(1, 4));
            r     = $urandom_range(0, 9);
            limit = (r == 0) ? 9'h1FF : (r == 1) ? 9'($urandom) : (r == 2) ? 9'd0
                                                 : 9'($urandom_range(1, 4));
            program_ramp(rand_seg_word(), rand_seg_word(), rand_seg_word(), rand_seg_word(),
                         count, limit);
            steady_flow = (phase % 4 == 3);
            if ($urandom_range(0, 1))
                send_item(OP_RESTART, 8'($urandom));
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                ms = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                 : 8'($urandom);
                send_item(($urandom_range(0, 24) == 0) ? OP_RESTART : OP_ADVANCE, ms);
            end
            steady_flow = 1'b0;
            settle();
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming with no gaps, so
    // the output register fills and the input has to stall.
    task automatic test_output_stall();
        program_ramp(rand_seg_word(), rand_seg_word(), rand_seg_word(), rand_seg_word(),
                     3'd4, 9'h1FF);
        send_item(OP_RESTART, 8'd0);
        steady_flow     = 1'b1;
        hold_off_cycles = 400;
        repeat (40) send_item(OP_ADVANCE, 8'($urandom));
        steady_flow = 1'b0;
        settle();
    endtask

    // One zero-length segment, so that each advance completes a pass: the largest loop
    // limit is reached, then the most negative limit lets the count saturate at 255.
    task automatic test_loop_saturation();
        program_ramp(seg_word(16'($urandom), 16'($urandom), 16'd0,
                              curve_code_t'($urandom_range(0, 7))),
                     '0, '0, '0, 3'd1, 9'd255);
        send_item(OP_RESTART, 8'($urandom));
        while (st_loops < 255)
            send_item(OP_ADVANCE, 8'($urandom));
        send_item(OP_ADVANCE, 8'($urandom));
        settle();
        write_reg(REG_LOOP_LIMIT, PDATA_W'(9'h100));
        apb_release();
        repeat (5) send_item(OP_ADVANCE, 8'($urandom));
        settle();
    endtask

    // The longest duration, stepped through mostly in full-size steps, so the elapsed
    // count climbs to its ceiling and the phase index covers the whole table.
    task automatic test_long_segment();
        program_ramp(seg_word(16'($urandom), 16'($urandom), 16'hFFFF,
                              curve_code_t'($urandom_range(0, 5))),
                     rand_seg_word(), rand_seg_word(), rand_seg_word(), 3'd1, 9'd1);
        send_item(OP_RESTART, 8'd0);
        while (st_loops == 0)
            send_item(OP_ADVANCE, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'hFF);
        send_item(OP_ADVANCE, 8'hFF);
        settle();
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and the test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        build_ease_table();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_segments();
        test_curve_shapes();
        test_finish_rules();
        test_random_ramps();
        test_output_stall();
        test_loop_saturation();
        test_long_segment();

        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Result side readiness: random stretches of ready and of stall, a long hold when a
    // test asks for one, and always ready in steady stretches.
    initial
    begin : result_sink
        int run;
        int r;
        run = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                m_tready        <= 1'b0;
                hold_off_cycles  = hold_off_cycles - 1;
            end
            else if (steady_flow)
                m_tready <= 1'b1;
            else if (run > 0)
                run = run - 1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    m_tready <= 1'b1;
                    run       = $urandom_range(0, 20);
                end
                else if (r < 95)
                begin
                    m_tready <= 1'b0;
                    run       = $urandom_range(0, 3);
                end
                else
                begin
                    m_tready <= 1'b0;
                    run       = $urandom_range(10, 50);
                end
            end
        end
    end

    function automatic void flag_field(input string what, input int want, input int got);
        fault_count = fault_count + 1;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Every result taken is compared, field by field, with the oldest one owed.
    initial
    begin : result_check
        result_t got;
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (tween_due.size() == 0)
                begin
                    fault_count = fault_count + 1;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = tween_due.pop_front();
                    if (got.value !== want.value)
                        flag_field("value", int'(want.value), int'(got.value));
                    if (got.finished !== want.finished)
                        flag_field("finished", int'(want.finished), int'(got.finished));
                    if (got.segment_now !== want.segment_now)
                        flag_field("segment_now", int'(want.segment_now),
                                   int'(got.segment_now));
                    if (got.loops_done !== want.loops_done)
                        flag_field("loops_done", int'(want.loops_done), int'(got.loops_done));
                end
            end
        end
    end

    // Watchdog: a run that hangs ends here.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

FILE: eased_ramp_sequencer.f
src/ers_pkg.sv
src/ers_alu.sv
src/ers_curve_rom.sv
src/ers_cfg_regs.sv
src/ers_seq.sv
src/eased_ramp_sequencer.sv
tb/tb.sv
